### sv/lsr_pkg.sv
// Shared definitions for the LIFO stack with reverse: request and status codes,
// the operation summary passed from the pointer unit, and default sizes.
// No dependencies.
package lsr_pkg;

   localparam int DEFAULT_DEPTH      = 256;
   localparam int DEFAULT_DATA_WIDTH = 32;
   localparam int VALUE_WIDTH        = 32;

   typedef enum logic [2:0] {
      REQ_PUSH    = 3'd0,
      REQ_POP     = 3'd1,
      REQ_PEEK    = 3'd2,
      REQ_CLEAR   = 3'd3,
      REQ_REVERSE = 3'd4
   } req_code_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      status_type status;
      logic       mem_write;
      logic       mem_read;
   } op_type;

endpackage

### sv/lsr_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// Standalone; no package dependencies.
module lsr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/lsr_ptr.sv
// Pointer unit of the stack: bottom index, entry count and direction bit.
// Decodes each request into a memory slot and access. Depends on lsr_pkg.
module lsr_ptr #(
   parameter int DEPTH = lsr_pkg::DEFAULT_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_fire,
   input  lsr_pkg::req_code_type      req_code,
   output lsr_pkg::op_type            op,
   output logic [$clog2(DEPTH)-1:0]   slot,
   output logic [$clog2(DEPTH+1)-1:0] count_next
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [AW-1:0] bottom_ff, bottom_in;
   logic [CW-1:0] count_ff, count_in;
   logic          reversed_ff, reversed_in;

   logic [CW:0]   push_sum, push_wrap, top_wrap;
   logic [AW-1:0] bottom_dec, bottom_inc;
   logic          is_full, is_empty;

   // Indices wrap modulo DEPTH, which need not be a power of two. Both sums stay
   // below twice DEPTH, so one compare and subtract is enough.
   always_comb begin
      push_sum  = {{(CW + 1 - AW){1'b0}}, bottom_ff} + {1'b0, count_ff};
      push_wrap = (push_sum >= (CW + 1)'(DEPTH)) ? push_sum - (CW + 1)'(DEPTH) : push_sum;
      top_wrap  = (push_sum > (CW + 1)'(DEPTH)) ? push_sum - (CW + 1)'(DEPTH + 1)
                                                : push_sum - (CW + 1)'(1);
      bottom_dec = (bottom_ff == '0) ? AW'(DEPTH - 1) : bottom_ff - AW'(1);
      bottom_inc = (bottom_ff == AW'(DEPTH - 1)) ? '0 : bottom_ff + AW'(1);
      is_full    = (count_ff == CW'(DEPTH));
      is_empty   = (count_ff == '0);
   end

   always_comb begin
      op.status    = lsr_pkg::STATUS_OK;
      op.mem_write = 1'b0;
      op.mem_read  = 1'b0;
      slot         = reversed_ff ? bottom_ff : top_wrap[AW-1:0];
      bottom_in    = bottom_ff;
      count_in     = count_ff;
      reversed_in  = reversed_ff;
      unique case (req_code)
         lsr_pkg::REQ_PUSH: begin
            if (is_full) begin
               op.status = lsr_pkg::STATUS_FULL;
            end else begin
               op.mem_write = 1'b1;
               count_in     = count_ff + CW'(1);
               if (reversed_ff) begin
                  slot      = bottom_dec;
                  bottom_in = bottom_dec;
               end else begin
                  slot = push_wrap[AW-1:0];
               end
            end
         end
         lsr_pkg::REQ_POP: begin
            if (is_empty) begin
               op.status = lsr_pkg::STATUS_EMPTY;
            end else begin
               op.mem_read = 1'b1;
               count_in    = count_ff - CW'(1);
               if (reversed_ff) begin
                  bottom_in = bottom_inc;
               end
            end
         end
         lsr_pkg::REQ_PEEK: begin
            if (is_empty) begin
               op.status = lsr_pkg::STATUS_EMPTY;
            end else begin
               op.mem_read = 1'b1;
            end
         end
         lsr_pkg::REQ_CLEAR: begin
            bottom_in   = '0;
            count_in    = '0;
            reversed_in = 1'b0;
         end
         lsr_pkg::REQ_REVERSE: begin
            if (is_empty) begin
               op.status = lsr_pkg::STATUS_EMPTY;
            end else begin
               reversed_in = ~reversed_ff;
            end
         end
         default: begin
         end
      endcase
   end

   assign count_next = count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         bottom_ff   <= '0;
         count_ff    <= '0;
         reversed_ff <= 1'b0;
      end else if (req_fire) begin
         bottom_ff   <= bottom_in;
         count_ff    <= count_in;
         reversed_ff <= reversed_in;
      end
   end

endmodule

### sv/lifo_stack_with_reverse.sv
// Top level of the LIFO stack with reverse: request/response handshake, response
// register and the entry memory. Depends on lsr_pkg, lsr_ram and lsr_ptr.
//
// Usage: a request carries req_type (push, pop, peek, clear, reverse) and
// req_push_value; it is taken when req_valid and req_ready are both high.
// Every request yields exactly one response on the rsp_ channel: the popped or
// peeked word, a status (ok, empty, full), the entry count after the request
// and an empty flag.
// Response timing: push, clear, reverse and refused requests answer from the response
// register in the cycle after acceptance; a pop or peek that hits the memory passes
// through ST_READ first, for the registered read port of the entry memory.
// Throughput: one request per cycle for requests that do not read the memory, while the
// receiver takes each response; a successful pop or peek holds req_ready low in ST_READ.
// Reset clears the count, the bottom index and the direction bit; the entry
// memory is not cleared, since a word is read only after it was written.
// When the receiver stalls, the response holds in its register and req_ready
// stays low until the response is taken or is being taken in that cycle.
module lifo_stack_with_reverse #(
   parameter int DEPTH      = lsr_pkg::DEFAULT_DEPTH,
   parameter int DATA_WIDTH = lsr_pkg::DEFAULT_DATA_WIDTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [2:0]                 req_type,
   input  logic signed [31:0]         req_push_value,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [31:0]         rsp_read_value,
   output logic [1:0]                 rsp_status,
   output logic [$clog2(DEPTH+1)-1:0] rsp_entry_count,
   output logic                       rsp_is_empty
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int VW = lsr_pkg::VALUE_WIDTH;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_READ = 2'b10
   } state_type;

   state_type state_ff, state_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0]         rsp_value_ff, rsp_value_in;
   lsr_pkg::status_type   rsp_status_ff, rsp_status_in;
   logic [CW-1:0]         rsp_count_ff, rsp_count_in;
   logic                  rsp_empty_ff, rsp_empty_in;

   logic                  req_fire;
   lsr_pkg::op_type       op;
   logic [AW-1:0]         slot;
   logic [CW-1:0]         count_next;
   logic [DATA_WIDTH-1:0] wr_data, rd_data;
   logic [VW-1:0]         rd_value;

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_fire  = req_valid && req_ready;

   lsr_ptr #(
      .DEPTH(DEPTH)
   ) u_ptr (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .req_code  (lsr_pkg::req_code_type'(req_type)),
      .op        (op),
      .slot      (slot),
      .count_next(count_next)
   );

   // Narrow stored words keep their low DATA_WIDTH bits and come back sign-extended; wide ones are zero-extended.
   generate
      if (DATA_WIDTH <= VW) begin : g_narrow
         assign wr_data = req_push_value[DATA_WIDTH-1:0];
      end else begin : g_wide
         assign wr_data = {{(DATA_WIDTH - VW){1'b0}}, req_push_value};
      end
      if (DATA_WIDTH >= VW) begin : g_rd_trunc
         assign rd_value = rd_data[VW-1:0];
      end else begin : g_rd_ext
         assign rd_value = {{(VW - DATA_WIDTH){rd_data[DATA_WIDTH-1]}}, rd_data};
      end
   endgenerate

   lsr_ram #(
      .WIDTH(DATA_WIDTH),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (req_fire && op.mem_write),
      .wr_addr(slot),
      .wr_data(wr_data),
      .rd_en  (req_fire && op.mem_read),
      .rd_addr(slot),
      .rd_data(rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_empty_in  = rsp_empty_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               rsp_status_in = op.status;
               rsp_count_in  = count_next;
               rsp_empty_in  = (count_next == '0);
               rsp_value_in  = '0;
               if (op.mem_read) begin
                  state_in = ST_READ;
               end else begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         ST_READ: begin
            rsp_value_in = rd_value;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_value  = rsp_value_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_is_empty    = rsp_empty_ff;

endmodule

### sv/lsr_check.sv
// Port-level checker for the LIFO stack with reverse, bound to the top level.
// Depends on lsr_pkg and lifo_stack_with_reverse.
module lsr_check #(
   parameter int DEPTH = lsr_pkg::DEFAULT_DEPTH
) (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic signed [31:0]         rsp_read_value,
   input logic [1:0]                 rsp_status,
   input logic [$clog2(DEPTH+1)-1:0] rsp_entry_count,
   input logic                       rsp_is_empty
);

   localparam int CW = $clog2(DEPTH + 1);

   // A stalled response keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_value)
         && $stable(rsp_status) && $stable(rsp_entry_count))
      else $error("response changed while stalled");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_is_empty == (rsp_entry_count == '0))
      else $error("empty flag disagrees with entry count");

   // A refused push can only happen with every entry in use.
   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == lsr_pkg::STATUS_FULL
         |-> rsp_entry_count == CW'(DEPTH) && rsp_read_value == '0)
      else $error("full status with free entries");

   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == lsr_pkg::STATUS_EMPTY
         |-> rsp_entry_count == '0 && rsp_read_value == '0)
      else $error("empty status with stored entries");

endmodule

bind lifo_stack_with_reverse lsr_check #(.DEPTH(DEPTH)) u_lsr_check (.*);

### test/tb_lifo_stack_with_reverse.sv
// Self-checking testbench for lifo_stack_with_reverse: directed, fill-to-capacity and
// random request traffic, each response checked against an in-bench stack predictor.
// Depends on lsr_pkg and the lifo_stack_with_reverse RTL.
module tb_lifo_stack_with_reverse;

   localparam int DEPTH       = lsr_pkg::DEFAULT_DEPTH;
   localparam int COUNT_WIDTH = $clog2(DEPTH + 1);
   localparam int STALL_LIMIT = 1000;
   localparam int MAX_REPORTS = 10;
   localparam int DRAIN_WAIT  = 8;

   // Request codes that the block treats as no operation.
   localparam logic [2:0] REQ_SPARE_FIRST = 3'd5;
   localparam logic [2:0] REQ_SPARE_LAST  = 3'd7;

   typedef struct packed {
      logic [31:0]            read_value;
      lsr_pkg::status_type    status;
      logic [COUNT_WIDTH-1:0] entry_count;
      logic                   is_empty;
   } stack_response_type;

   logic                   clock          = 1'b0;
   logic                   reset          = 1'b1;
   logic                   req_valid      = 1'b0;
   logic                   req_ready;
   logic [2:0]             req_type       = lsr_pkg::REQ_PUSH;
   logic signed [31:0]     req_push_value = '0;
   logic                   rsp_valid;
   logic                   rsp_ready      = 1'b0;
   logic signed [31:0]     rsp_read_value;
   logic [1:0]             rsp_status;
   logic [COUNT_WIDTH-1:0] rsp_entry_count;
   logic                   rsp_is_empty;

   // Predicted stack contents and pointers.
   logic [31:0] stack_words [DEPTH];
   int          stack_bottom   = 0;
   int          stack_count    = 0;
   logic        stack_reversed = 1'b0;

   stack_response_type pending_responses[$];

   bit pacing_on       = 1'b1;
   int mismatch_count  = 0;
   int requests_sent   = 0;
   int responses_seen  = 0;
   int refused_pushes  = 0;
   int empty_reports   = 0;
   int reversals       = 0;
   int deepest         = 0;
   int quiet_cycles    = 0;

   lifo_stack_with_reverse u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_push_value  (req_push_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_read_value  (rsp_read_value),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count),
      .rsp_is_empty    (rsp_is_empty)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Applies one request to the predicted stack and returns the response it must produce.
   function automatic stack_response_type predict_response(input logic [2:0] code,
                                                           input logic [31:0] word);
      stack_response_type r;
      int slot;
      r = '0;
      r.status = lsr_pkg::STATUS_OK;
      case (code)
         lsr_pkg::REQ_PUSH: begin
            if (stack_count >= DEPTH) begin
               r.status = lsr_pkg::STATUS_FULL;
               refused_pushes++;
            end else begin
               if (stack_reversed) begin
                  stack_bottom = (stack_bottom + DEPTH - 1) % DEPTH;
                  slot = stack_bottom;
               end else begin
                  slot = (stack_bottom + stack_count) % DEPTH;
               end
               stack_words[slot] = word;
               stack_count++;
            end
         end
         lsr_pkg::REQ_POP, lsr_pkg::REQ_PEEK: begin
            if (stack_count == 0) begin
               r.status = lsr_pkg::STATUS_EMPTY;
            end else begin
               slot = stack_reversed ? stack_bottom : (stack_bottom + stack_count - 1) % DEPTH;
               r.read_value = stack_words[slot];
               if (code == lsr_pkg::REQ_POP) begin
                  if (stack_reversed) stack_bottom = (stack_bottom + 1) % DEPTH;
                  stack_count--;
               end
            end
         end
         lsr_pkg::REQ_CLEAR: begin
            stack_count    = 0;
            stack_bottom   = 0;
            stack_reversed = 1'b0;
         end
         lsr_pkg::REQ_REVERSE: begin
            if (stack_count == 0) begin
               r.status = lsr_pkg::STATUS_EMPTY;
            end else begin
               stack_reversed = ~stack_reversed;
               reversals++;
            end
         end
         default: ;
      endcase
      if (r.status == lsr_pkg::STATUS_EMPTY) empty_reports++;
      if (stack_count > deepest) deepest = stack_count;
      r.entry_count = COUNT_WIDTH'(stack_count);
      r.is_empty    = (stack_count == 0);
      return r;
   endfunction

   function automatic logic [31:0] random_word();
      case ($urandom_range(0, 15))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'hFFFF_FFFF;
         3:       return 32'h0000_0000;
         default: return $urandom;
      endcase
   endfunction

   // Called at a rising edge; returns at the edge where the request is accepted, with
   // req_valid still high so that a back-to-back request needs no second assignment.
   task automatic send_request(input logic [2:0] code, input logic [31:0] word);
      int gap;
      gap = pacing_on ? $urandom_range(0, 7) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= code;
      req_push_value <= word;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_responses.push_back(predict_response(code, word));
      requests_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_responses.size() != 0) @(posedge clock);
   endtask

   task automatic test_empty_and_extremes();
      pacing_on = 1'b1;
      send_request(lsr_pkg::REQ_POP, random_word());
      send_request(lsr_pkg::REQ_PEEK, random_word());
      send_request(lsr_pkg::REQ_REVERSE, random_word());
      for (int c = REQ_SPARE_FIRST; c <= REQ_SPARE_LAST; c++) begin
         send_request(c[2:0], random_word());
      end
      send_request(lsr_pkg::REQ_PUSH, 32'h7FFF_FFFF);
      send_request(lsr_pkg::REQ_PUSH, 32'h8000_0000);
      send_request(lsr_pkg::REQ_PUSH, 32'h0000_0000);
      send_request(lsr_pkg::REQ_PUSH, 32'hFFFF_FFFF);
      send_request(lsr_pkg::REQ_PEEK, random_word());
      send_request(lsr_pkg::REQ_REVERSE, random_word());
      send_request(lsr_pkg::REQ_PEEK, random_word());
      // With the order reversed a push lands below index zero and wraps around.
      send_request(lsr_pkg::REQ_PUSH, 32'h1234_5678);
      send_request(lsr_pkg::REQ_POP, random_word());
      send_request(lsr_pkg::REQ_PEEK, random_word());
      send_request(lsr_pkg::REQ_REVERSE, random_word());
      repeat (4) send_request(lsr_pkg::REQ_POP, random_word());
      send_request(lsr_pkg::REQ_POP, random_word());
      send_request(lsr_pkg::REQ_PUSH, 32'hA5A5_A5A5);
      send_request(lsr_pkg::REQ_REVERSE, random_word());
      send_request(lsr_pkg::REQ_CLEAR, random_word());
      send_request(lsr_pkg::REQ_PEEK, random_word());
   endtask

   task automatic test_fill_to_capacity();
      pacing_on = 1'b0;
      send_request(lsr_pkg::REQ_CLEAR, random_word());
      repeat (100) send_request(lsr_pkg::REQ_PUSH, random_word());
      send_request(lsr_pkg::REQ_REVERSE, random_word());
      repeat (DEPTH - 100) send_request(lsr_pkg::REQ_PUSH, random_word());
      pacing_on = 1'b1;
      repeat (2) send_request(lsr_pkg::REQ_PUSH, random_word());
      send_request(lsr_pkg::REQ_PEEK, random_word());
      send_request(lsr_pkg::REQ_REVERSE, random_word());
      send_request(lsr_pkg::REQ_PEEK, random_word());
      repeat (30) send_request(lsr_pkg::REQ_POP, random_word());
      repeat (31) send_request(lsr_pkg::REQ_PUSH, random_word());
      send_request(lsr_pkg::REQ_REVERSE, random_word());
      repeat (10) send_request(lsr_pkg::REQ_POP, random_word());
      send_request(lsr_pkg::REQ_CLEAR, random_word());
   endtask

   task automatic test_random_traffic();
      int         pick;
      bit         push_heavy;
      logic [2:0] code;
      for (int seg = 0; seg < 10; seg++) begin
         pacing_on  = ($urandom_range(0, 3) != 0);
         push_heavy = ($urandom_range(0, 2) != 0);
         if (seg == 4) wait_drained();
         for (int n = 0; n < 50; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 2) code = lsr_pkg::REQ_CLEAR;
            else if (pick < 5) code = 3'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST));
            else if (pick < 15) code = lsr_pkg::REQ_REVERSE;
            else if (pick < 28) code = lsr_pkg::REQ_PEEK;
            else if (pick < (push_heavy ? 80 : 55)) code = lsr_pkg::REQ_PUSH;
            else code = lsr_pkg::REQ_POP;
            send_request(code, random_word());
         end
      end
   endtask

   // Response side: random stall before each response while pacing is on, then compare with
   // the oldest prediction.
   always @(posedge clock) begin : check_responses
      stack_response_type got;
      stack_response_type want;
      static int hold = 0;
      if (reset) begin
         rsp_ready <= 1'b0;
         hold = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            responses_seen++;
            got = '{rsp_read_value, lsr_pkg::status_type'(rsp_status), rsp_entry_count,
                    rsp_is_empty};
            if (pending_responses.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("unexpected response: value %h status %0d count %0d empty %0b",
                           got.read_value, got.status, got.entry_count, got.is_empty);
            end else begin
               want = pending_responses.pop_front();
               if (got !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS)
                     $display({"response %0d mismatch: expected value %h status %0d count %0d",
                               " empty %0b, got value %h status %0d count %0d empty %0b"},
                              responses_seen, want.read_value, want.status,
                              want.entry_count, want.is_empty, got.read_value, got.status,
                              got.entry_count, got.is_empty);
               end
            end
            hold = pacing_on ? $urandom_range(0, 7) : 0;
         end
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            hold--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog: no request or response accepted for %0d cycles", quiet_cycles);
         $display("[lifo_stack_with_reverse] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_empty_and_extremes();
      wait_drained();
      test_fill_to_capacity();
      wait_drained();
      test_random_traffic();
      wait_drained();
      repeat (DRAIN_WAIT) @(posedge clock);
      $display("%0d requests sent, %0d responses checked, %0d mismatches", requests_sent,
               responses_seen, mismatch_count);
      $display("deepest stack %0d, %0d refused pushes, %0d empty reports, %0d reversals",
               deepest, refused_pushes, empty_reports, reversals);
      if (mismatch_count == 0) begin
         $display("[lifo_stack_with_reverse] OK");
      end else begin
         $display("[lifo_stack_with_reverse] ERROR");
      end
      $finish;
   end

endmodule
